// ===== design/skvt_pkg.sv =====
// Shared types, sizes and codes for the sorted key/value table.
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // Match flags and hit values are OR-reduced in groups of this size.
    localparam int GROUP   = 16;
    localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CHANGE = 2'd2;
    localparam logic [1:0] CMD_ERASE  = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EXISTS    = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_in;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] entry_count;
    } t_out;

    // Per-cycle control broadcast to every cell.
    typedef struct packed {
        logic cap;  // capture compare flags against the query key
        logic ins;  // shift up and insert
        logic chg;  // overwrite the value of the matching entry
        logic del;  // shift down over the matching entry
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/skvt_cell.sv =====
// One table slot: holds a key/value pair and its compare flags.
`default_nettype none

module skvt_cell
    import skvt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic                  i_occ,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0] i_val,
    input  wire logic                  i_prev_lt,
    input  wire logic [KEY_BITS-1:0]   i_prev_key,
    input  wire logic [VALUE_BITS-1:0] i_prev_val,
    input  wire logic [KEY_BITS-1:0]   i_next_key,
    input  wire logic [VALUE_BITS-1:0] i_next_val,
    output logic [KEY_BITS-1:0]        o_key,
    output logic [VALUE_BITS-1:0]      o_val,
    output logic                       o_lt,
    output logic                       o_eq,
    output logic [VALUE_BITS-1:0]      o_hval
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_lt;
    logic                  r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_lt <= i_occ && (r_key < i_key);
            r_eq <= i_occ && (r_key == i_key);
        end
        if (i_ctl.ins) begin
            // Entries below the new key hold; the first slot above takes it.
            if (!r_lt) begin
                if (i_prev_lt) begin
                    r_key <= i_key;
                    r_val <= i_val;
                end else begin
                    r_key <= i_prev_key;
                    r_val <= i_prev_val;
                end
            end
        end else if (i_ctl.del) begin
            if (i_occ && !r_lt) begin
                r_key <= i_next_key;
                r_val <= i_next_val;
            end
        end else if (i_ctl.chg && r_eq) begin
            r_val <= i_val;
        end
    end

    assign o_key  = r_key;
    assign o_val  = r_val;
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;
    assign o_hval = r_eq ? r_val : '0;

endmodule

`default_nettype wire

// ===== design/skvt_reduce.sv =====
// Registered group OR of the cells' match flags and hit values.
`default_nettype none

module skvt_reduce
    import skvt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [CAPACITY-1:0]   i_eq,
    input  wire logic [VALUE_BITS-1:0] i_hval [CAPACITY],
    output logic [NGROUPS-1:0]         o_grp_hit,
    output logic [VALUE_BITS-1:0]      o_grp_val [NGROUPS]
);

    logic [NGROUPS-1:0]    n_grp_hit;
    logic [VALUE_BITS-1:0] n_grp_val [NGROUPS];
    logic [NGROUPS-1:0]    r_grp_hit;
    logic [VALUE_BITS-1:0] r_grp_val [NGROUPS];

    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            n_grp_hit[g] = 1'b0;
            n_grp_val[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < CAPACITY) begin
                    n_grp_hit[g] = n_grp_hit[g] | i_eq[g * GROUP + j];
                    n_grp_val[g] = n_grp_val[g] | i_hval[g * GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_hit <= n_grp_hit;
        r_grp_val <= n_grp_val;
    end

    assign o_grp_hit = r_grp_hit;
    assign o_grp_val = r_grp_val;

endmodule

`default_nettype wire

// ===== design/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: cell row, reduction and command control.
//
// Usage: commands enter on the input channel (i_in_valid / o_in_stall /
// i_in_data) as {cmd, key, value}; each command gives exactly one result on
// the output channel (o_out_valid / i_out_stall / o_out_data) as
// {found, read_value, status, entry_count}. A transfer happens at a rising
// edge where valid is high and stall is low.
// Each command passes compare, reduce and commit in order: the row of cells
// compares all slots in parallel, a registered group OR tree reduces the flags,
// and the commit applies the shift or write across the whole row at once.
// Only one command is in flight, so o_in_stall is high from transfer to
// commit. The output register parts the channels: the next command is taken
// while a result still waits. A stalled result holds; the commit of the
// following command waits until the output register is free.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending
// result; slot contents are not cleared since only slots below the count
// are ever read.
`default_nettype none

module sorted_key_value_table
    import skvt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a command
    localparam logic [1:0] ST_CMP  = 2'd1;  // cells capture compare flags
    localparam logic [1:0] ST_RED  = 2'd2;  // group OR tree settles
    localparam logic [1:0] ST_FIN  = 2'd3;  // decide, commit, load result

    logic [1:0]            r_state, n_state;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;
    t_in                   r_in;
    t_cell_ctl             w_ctl;

    logic                  w_in_xfer;
    logic                  w_out_free;
    logic                  w_hit;
    logic [VALUE_BITS-1:0] w_rdv;
    logic                  w_full;

    // Cell row wiring.
    logic [KEY_BITS-1:0]   w_key  [CAPACITY];
    logic [VALUE_BITS-1:0] w_val  [CAPACITY];
    logic [VALUE_BITS-1:0] w_hval [CAPACITY];
    logic [CAPACITY-1:0]   w_lt;
    logic [CAPACITY-1:0]   w_eq;
    logic [NGROUPS-1:0]    w_grp_hit;
    logic [VALUE_BITS-1:0] w_grp_val [NGROUPS];

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == COUNT_BITS'(CAPACITY));

    // Hold the accepted command for the cells and the decision logic.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in_data;
        end
    end

    // Row of cells; each slot sees its neighbors below and above.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(i);

        logic                  w_prev_lt;
        logic [KEY_BITS-1:0]   w_prev_key;
        logic [VALUE_BITS-1:0] w_prev_val;
        logic [KEY_BITS-1:0]   w_next_key;
        logic [VALUE_BITS-1:0] w_next_val;

        if (i == 0) begin : g_first
            // Nothing sits below slot zero, so it takes the new key unless its own key is smaller.
            assign w_prev_lt  = 1'b1;
            assign w_prev_key = w_key[i];
            assign w_prev_val = w_val[i];
        end else begin : g_mid
            assign w_prev_lt  = w_lt[i-1];
            assign w_prev_key = w_key[i-1];
            assign w_prev_val = w_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            // Top slot falls out of range after an erase; keep its contents.
            assign w_next_key = w_key[i];
            assign w_next_val = w_val[i];
        end else begin : g_below_top
            assign w_next_key = w_key[i+1];
            assign w_next_val = w_val[i+1];
        end

        skvt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (IDX < r_count),
            .i_key      (r_in.key),
            .i_val      (r_in.value),
            .i_prev_lt  (w_prev_lt),
            .i_prev_key (w_prev_key),
            .i_prev_val (w_prev_val),
            .i_next_key (w_next_key),
            .i_next_val (w_next_val),
            .o_key      (w_key[i]),
            .o_val      (w_val[i]),
            .o_lt       (w_lt[i]),
            .o_eq       (w_eq[i]),
            .o_hval     (w_hval[i])
        );
    end

    skvt_reduce u_reduce (
        .i_clk     (i_clk),
        .i_eq      (w_eq),
        .i_hval    (w_hval),
        .o_grp_hit (w_grp_hit),
        .o_grp_val (w_grp_val)
    );

    // Final OR over the group partials.
    always_comb begin
        w_hit = |w_grp_hit;
        w_rdv = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            w_rdv = w_rdv | w_grp_val[g];
        end
    end

    // Command decision and commit.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ctl       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                w_ctl.cap = 1'b1;
                n_state   = ST_RED;
            end
            ST_RED: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out.found      = w_hit;
                    n_out.read_value = '0;
                    n_out.status     = STS_OK;
                    unique case (r_in.cmd)
                        CMD_INSERT: begin
                            if (w_hit) begin
                                n_out.status = STS_EXISTS;
                            end else if (w_full) begin
                                n_out.status = STS_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (w_hit) begin
                                n_out.read_value = w_rdv;
                            end else begin
                                n_out.status = STS_NOT_FOUND;
                            end
                        end
                        CMD_CHANGE: begin
                            if (w_hit) begin
                                w_ctl.chg = 1'b1;
                            end else begin
                                n_out.status = STS_NOT_FOUND;
                            end
                        end
                        CMD_ERASE: begin
                            if (w_hit) begin
                                w_ctl.del = 1'b1;
                                n_count   = r_count - 1'b1;
                            end else begin
                                n_out.status = STS_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_out.status = STS_NOT_FOUND;
                        end
                    endcase
                    n_out.entry_count = n_count;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A fresh result only ever follows a commit cycle.
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result appeared without a commit cycle");

    // The count never passes the table size.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(CAPACITY))
        else $error("entry count exceeds capacity");

    // An accepted command walks compare then reduce before deciding.
    a_cmd_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_CMP) ##1 (r_state == ST_RED))
        else $error("command did not advance through compare and reduce");

    // A table-full report only comes from a full table.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != STS_FULL
                         || o_out_data.entry_count == COUNT_BITS'(CAPACITY)))
        else $error("full status with table not full");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the sorted key/value table: directed rows, then random command traffic.
`timescale 1ns / 1ps

module tb_top;
    import skvt_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT = 19;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT_CMD = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // One row of the directed table. When typed is set, want is the result
    // read straight off the behavior; otherwise the shadow table decides.
    typedef struct packed {
        t_in  cmd;
        bit   typed;
        t_out want;
    } dir_row_t;

    localparam int NUM_DIRECTED = 21;
    localparam dir_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
        // empty table: every probe misses
        '{'{CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{1'b0, 32'h0000_0000, STS_NOT_FOUND, 9'd0}},
        '{'{CMD_ERASE,  32'h0000_0005, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 32'h0000_0000, STS_NOT_FOUND, 9'd0}},
        '{'{CMD_CHANGE, 32'h0000_0005, 32'h0000_1234}, 1'b1,
          '{1'b0, 32'h0000_0000, STS_NOT_FOUND, 9'd0}},
        // key and value extremes
        '{'{CMD_INSERT, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{1'b0, 32'h0000_0000, STS_OK, 9'd1}},
        '{'{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 32'h0000_0000, STS_OK, 9'd2}},
        '{'{CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5}, 1'b1,
          '{1'b0, 32'h0000_0000, STS_OK, 9'd3}},
        // duplicate insert leaves the table alone
        '{'{CMD_INSERT, 32'h0000_0000, 32'h0000_0001}, 1'b1,
          '{1'b1, 32'h0000_0000, STS_EXISTS, 9'd3}},
        '{'{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, STS_OK, 9'd3}},
        '{'{CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1,
          '{1'b1, 32'h0000_0000, STS_OK, 9'd3}},
        '{'{CMD_CHANGE, 32'h8000_0000, 32'h5A5A_5A5A}, 1'b1,
          '{1'b1, 32'h0000_0000, STS_OK, 9'd3}},
        '{'{CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000}, 1'b1,
          '{1'b1, 32'h5A5A_5A5A, STS_OK, 9'd3}},
        '{'{CMD_LOOKUP, 32'h0000_0001, 32'h0000_0000}, 1'b1,
          '{1'b0, 32'h0000_0000, STS_NOT_FOUND, 9'd3}},
        // inserts in the middle and at the low end, then probes after shifts
        '{'{CMD_INSERT, 32'h7FFF_FFFF, 32'h0F0F_0F0F}, 1'b0, '0},
        '{'{CMD_INSERT, 32'h0000_0001, 32'hF0F0_F0F0}, 1'b0, '0},
        '{'{CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_ERASE,  32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{1'b1, 32'h0000_0000, STS_OK, 9'd4}},
        '{'{CMD_LOOKUP, 32'h0000_0001, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_ERASE,  32'h8000_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_ERASE,  32'h8000_0000, 32'h0000_0000}, 1'b1,
          '{1'b0, 32'h0000_0000, STS_NOT_FOUND, 9'd3}},
        '{'{CMD_CHANGE, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    // Knobs shared by the sender and the receiver.
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // Shadow copy of the table, advanced once per command in send order.
    logic [KEY_BITS-1:0]   tbl_key [CAPACITY];
    logic [VALUE_BITS-1:0] tbl_val [CAPACITY];
    int                    tbl_count = 0;

    t_out pending_results[$];
    int   cmds_sent = 0;
    int   mismatches = 0;

    sorted_key_value_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Apply one command to the shadow table and return the result it gives.
    function automatic t_out table_apply(input t_in c);
        int   pos;
        int   slot;
        t_out r;
        pos = tbl_count;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_key[i] == c.key && pos == tbl_count) begin
                pos = i;
            end
        end
        r = '0;
        r.found = (pos < tbl_count);
        if (c.cmd == CMD_INSERT) begin
            if (r.found) begin
                r.status = STS_EXISTS;
            end else if (tbl_count >= CAPACITY) begin
                r.status = STS_FULL;
            end else begin
                // find the sorted slot, open a gap and drop the pair in
                slot = 0;
                while (slot < tbl_count && tbl_key[slot] < c.key) begin
                    slot++;
                end
                for (int i = tbl_count; i > slot; i--) begin
                    tbl_key[i] = tbl_key[i-1];
                    tbl_val[i] = tbl_val[i-1];
                end
                tbl_key[slot] = c.key;
                tbl_val[slot] = c.value;
                tbl_count++;
                r.status = STS_OK;
            end
        end else if (!r.found) begin
            r.status = STS_NOT_FOUND;
        end else begin
            r.status = STS_OK;
            if (c.cmd == CMD_LOOKUP) begin
                r.read_value = tbl_val[pos];
            end else if (c.cmd == CMD_CHANGE) begin
                tbl_val[pos] = c.value;
            end else begin
                // close the gap over the erased entry
                for (int i = pos; i + 1 < tbl_count; i++) begin
                    tbl_key[i] = tbl_key[i+1];
                    tbl_val[i] = tbl_val[i+1];
                end
                tbl_count--;
            end
        end
        r.entry_count = COUNT_BITS'(tbl_count);
        return r;
    endfunction

    // Draw a key: a stored one, a corner value, or anything at all.
    function automatic logic [KEY_BITS-1:0] choose_key(input int hit_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (tbl_count > 0 && roll < hit_pct) begin
            return tbl_key[$urandom_range(0, tbl_count - 1)];
        end else if (roll < hit_pct + 10) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return KEY_BITS'($urandom_range(0, 15));
                default: return ~KEY_BITS'($urandom_range(0, 15));
            endcase
        end
        return $urandom();
    endfunction

    // Build a random command; inserts mostly aim at new keys, the rest at stored ones.
    function automatic t_in random_cmd(input int ins_pct, input int ers_pct);
        int  roll;
        t_in c;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            c.cmd = CMD_INSERT;
        end else if (roll < ins_pct + ers_pct) begin
            c.cmd = CMD_ERASE;
        end else if (roll[0]) begin
            c.cmd = CMD_LOOKUP;
        end else begin
            c.cmd = CMD_CHANGE;
        end
        c.key   = choose_key(c.cmd == CMD_INSERT ? 15 : 70);
        c.value = $urandom();
        return c;
    endfunction

    // Queue the expected result and hold the command until its transfer.
    // Entered and left at a falling edge; valid stays high on return so
    // back-to-back commands never toggle it within one step.
    task automatic send_cmd(input t_in c, input bit typed, input t_out want);
        t_out predicted;
        predicted = table_apply(c);
        pending_results.push_back(typed ? want : predicted);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do begin
            @(posedge i_clk);
        end while (in_stall);
        cmds_sent++;
        if (cmds_sent == HOLD_AT_CMD) begin
            hold_req <= 1'b1;
        end
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n, input int ins_pct, input int ers_pct);
        for (int i = 0; i < n; i++) begin
            send_cmd(random_cmd(ins_pct, ers_pct), 1'b0, '0);
        end
    endtask

    task automatic note_mismatch(input string what, input t_out want, input t_out got);
        if (mismatches < REPORT_LIMIT) begin
            $display("%0t: %s: expected found=%0b value=%h status=%0d count=%0d",
                     $realtime, what, want.found, want.read_value, want.status,
                     want.entry_count);
            $display("    got found=%0b value=%h status=%0d count=%0d",
                     got.found, got.read_value, got.status, got.entry_count);
        end
        mismatches++;
    endtask

    // Receiver: random stalls, one long hold-off to back the block up, calm windows.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Checker: compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, out_data);
            end else begin
                want = pending_results.pop_front();
                if (out_data.found !== want.found
                        || out_data.read_value !== want.read_value
                        || out_data.status !== want.status
                        || out_data.entry_count !== want.entry_count) begin
                    note_mismatch("result mismatch", want, out_data);
                end
            end
        end
    end

    initial begin
        int guard;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_cmd(DIRECTED[r].cmd, DIRECTED[r].typed, DIRECTED[r].want);
        end

        // Mixed traffic, with a stretch where neither side idles.
        send_random(10, 35, 20);
        calm <= 1'b1;
        send_random(20, 35, 20);
        calm <= 1'b0;
        send_random(10, 35, 20);

        // Fill the table up to capacity; the long hold-off lands in here.
        guard = 0;
        while (tbl_count < CAPACITY && guard < 1000) begin
            send_cmd(random_cmd(90, 3), 1'b0, '0);
            guard++;
        end

        // Probe the full table: duplicate inserts, rejected inserts, hits.
        send_random(30, 50, 10);

        // Drain back down, then a last mixed stretch.
        guard = 0;
        while (tbl_count > 200 && guard < 1000) begin
            send_cmd(random_cmd(5, 85), 1'b0, '0);
            guard++;
        end
        send_random(30, 30, 30);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("sorted_key_value_table test passed");
        end else begin
            $display("sorted_key_value_table test failed");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #3_000_000;
        $display("sorted_key_value_table test failed");
        $finish;
    end

endmodule
